// ===== src/sspc_pkg.sv =====
package sspc_pkg;

    // Number of bytes after which a line is closed even without a NUL.
    localparam int unsigned LINE_LENGTH = 32;
    localparam int unsigned COUNT_W     = $clog2(LINE_LENGTH);

    localparam int unsigned HALF_W      = 16;
    localparam int unsigned VALUE_W     = 17;
    localparam int unsigned TOGGLE_W    = 17;

    localparam logic [HALF_W-1:0] HALF_PERIOD_RESET = 16'd37735;

    // Operation codes of an input item.
    localparam logic [1:0] OP_BYTE    = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_ENDSTOP = 2'd2;

    // Status codes of a result item.
    localparam logic [1:0] ST_NONE    = 2'd0;
    localparam logic [1:0] ST_BAD     = 2'd1;
    localparam logic [1:0] ST_DONE    = 2'd2;
    localparam logic [1:0] ST_ENDSTOP = 2'd3;

    // Parser phases.
    localparam logic [1:0] PH_SPACE = 2'd0;
    localparam logic [1:0] PH_SIGN  = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    // Outcome of a byte as seen by the pulse generator.
    typedef struct packed {
        logic              line_end;
        logic              value_ok;
        logic [HALF_W-1:0] value;
    } t_line;

    // Pulse generator state after the current item.
    typedef struct packed {
        logic       step_level;
        logic       drivers_on;
        logic [1:0] status;
    } t_pulse;

endpackage

// ===== src/serial_setpoint_step_pulse_controller_core.sv =====
// Serial setpoint step pulse controller.
//
// Input channel (i_valid / o_stall): each item carries an operation code and a
// received byte. A byte item is echoed and parsed as a decimal number; a NUL,
// or the last byte of a full line, closes the line and a value from 1 to 65535
// starts a pulse run of that many steps. A tick item advances a running pulse
// train, and an endstop item stops everything at once.
// Output channel (o_valid / i_stall): exactly one result item per input item,
// in order, holding the echo, the step level, the driver enable and a status.
// Configuration channel (i_cfg_valid / o_cfg_ready): writes the half period in
// ticks minus one; it is always ready and should be written while idle.
// The result of an item accepted at one edge is registered and valid after that
// edge. Throughput is one item per cycle, limited only by the single result
// register. When the receiver stalls, the result is held and o_stall is
// raised towards the sender only while the result register is full and stalled,
// so a new item is taken in the same cycle a waiting result is taken.
// Reset (synchronous, active low) clears the parser, the pulse run, the valid
// flag of the result register and sets the half period to 37735.
module serial_setpoint_step_pulse_controller_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_echo_valid,
    output logic [7:0]  o_echo_byte,
    output logic        o_step_level,
    output logic        o_drivers_enabled,
    output logic [1:0]  o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_half_period
);
    import sspc_pkg::*;

    logic              accept;
    logic              is_byte;
    t_line             line;
    t_pulse            pulse;

    logic [HALF_W-1:0] r_half_period;
    logic              r_out_valid;
    logic              r_echo_valid;
    logic [7:0]        r_echo_byte;
    logic              r_step_level;
    logic              r_drivers;
    logic [1:0]        r_status;

    // The result register frees up in the same cycle it is taken downstream.
    assign o_stall     = r_out_valid && i_stall;
    assign accept      = i_valid && !o_stall;
    assign is_byte     = (i_operation == OP_BYTE);
    assign o_cfg_ready = 1'b1;

    sspc_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte_en (accept && is_byte),
        .i_rx_byte (i_rx_byte),
        .o_line    (line)
    );

    sspc_pulse u_pulse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_operation   (i_operation),
        .i_line        (line),
        .i_half_period (r_half_period),
        .o_pulse       (pulse)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_PERIOD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_half_period <= i_cfg_half_period;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload of the result register; the echo is the byte itself, the rest comes from the pulse generator.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_echo_valid <= is_byte;
            r_echo_byte  <= is_byte ? i_rx_byte : 8'h00;
            r_step_level <= pulse.step_level;
            r_drivers    <= pulse.drivers_on;
            r_status     <= pulse.status;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_echo_valid      = r_echo_valid;
    assign o_echo_byte       = r_echo_byte;
    assign o_step_level      = r_step_level;
    assign o_drivers_enabled = r_drivers;
    assign o_status          = r_status;

endmodule

// ===== src/sspc_parser.sv =====
module sspc_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_byte_en,
    input  logic [7:0]      i_rx_byte,
    output sspc_pkg::t_line o_line
);
    import sspc_pkg::*;

    logic [1:0]         r_phase, n_phase;
    logic               r_negative, n_negative;
    logic [VALUE_W-1:0] r_value, n_value;
    logic               r_overflow, n_overflow;
    logic [COUNT_W-1:0] r_count, n_count;

    logic               is_digit;
    logic               is_space;
    logic [3:0]         digit;
    logic [VALUE_W+3:0] acc;
    logic [COUNT_W:0]   count_inc;
    logic               line_end;

    assign is_digit  = (i_rx_byte >= 8'h30) && (i_rx_byte <= 8'h39);
    assign is_space  = (i_rx_byte == 8'h20) || ((i_rx_byte >= 8'd9) && (i_rx_byte <= 8'd13));
    assign digit     = i_rx_byte[3:0];
    // value * 10 + digit, formed as two shifts and two adds.
    assign acc       = {1'b0, r_value, 3'b000} + {3'b000, r_value, 1'b0}
                     + {{VALUE_W{1'b0}}, digit};
    assign count_inc = {1'b0, r_count} + (COUNT_W+1)'(1);
    assign line_end  = (i_rx_byte == 8'h00) || (count_inc >= (COUNT_W+1)'(LINE_LENGTH));

    always_comb begin
        n_phase    = r_phase;
        n_negative = r_negative;
        n_value    = r_value;
        n_overflow = r_overflow;

        if ((r_phase == PH_SPACE) && !is_digit && !is_space) begin
            if ((i_rx_byte == 8'h2B) || (i_rx_byte == 8'h2D)) begin
                n_negative = (i_rx_byte == 8'h2D);
                n_phase    = PH_SIGN;
            end else begin
                n_phase = PH_DONE;
            end
        end else if (((r_phase == PH_SIGN) || (r_phase == PH_DIGIT)) && !is_digit) begin
            n_phase = PH_DONE;
        end else if ((r_phase != PH_DONE) && is_digit) begin
            n_phase = PH_DIGIT;
            if (r_overflow || (acc > (VALUE_W+4)'(65535))) begin
                n_overflow = 1'b1;
                n_value    = VALUE_W'(65536);
            end else begin
                n_value = acc[VALUE_W-1:0];
            end
        end

        o_line.line_end = line_end;
        o_line.value_ok = !n_negative && !n_overflow && (n_value != '0) && !n_value[VALUE_W-1];
        o_line.value    = n_value[HALF_W-1:0];

        if (line_end) begin
            n_phase    = PH_SPACE;
            n_negative = 1'b0;
            n_value    = '0;
            n_overflow = 1'b0;
            n_count    = '0;
        end else begin
            n_count = count_inc[COUNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SPACE;
            r_negative <= 1'b0;
            r_value    <= '0;
            r_overflow <= 1'b0;
            r_count    <= '0;
        end else if (i_byte_en) begin
            r_phase    <= n_phase;
            r_negative <= n_negative;
            r_value    <= n_value;
            r_overflow <= n_overflow;
            r_count    <= n_count;
        end
    end

endmodule

// ===== src/sspc_pulse.sv =====
module sspc_pulse (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [1:0]                    i_operation,
    input  sspc_pkg::t_line               i_line,
    input  logic [sspc_pkg::HALF_W-1:0]   i_half_period,
    output sspc_pkg::t_pulse              o_pulse
);
    import sspc_pkg::*;

    logic [HALF_W-1:0]   r_steps, n_steps;
    logic [TOGGLE_W-1:0] r_toggles, n_toggles;
    logic [HALF_W-1:0]   r_period, n_period;
    logic                r_running, n_running;
    logic                r_level, n_level;
    logic                r_drivers, n_drivers;
    logic [1:0]          status;

    always_comb begin
        n_steps   = r_steps;
        n_toggles = r_toggles;
        n_period  = r_period;
        n_running = r_running;
        n_level   = r_level;
        n_drivers = r_drivers;
        status    = ST_NONE;

        case (i_operation)
            OP_BYTE: begin
                if (i_line.line_end) begin
                    if (i_line.value_ok) begin
                        n_steps   = i_line.value;
                        n_toggles = '0;
                        n_period  = '0;
                        n_running = 1'b1;
                        n_drivers = 1'b1;
                    end else begin
                        n_steps = '0;
                        status  = ST_BAD;
                    end
                end
            end
            OP_TICK: begin
                if (r_running) begin
                    if (r_period >= i_half_period) begin
                        n_period = '0;
                        if (r_toggles < {r_steps, 1'b0}) begin
                            n_toggles = r_toggles + TOGGLE_W'(1);
                            n_level   = !r_level;
                        end else begin
                            n_steps   = '0;
                            n_toggles = '0;
                            n_running = 1'b0;
                            n_drivers = 1'b0;
                            n_level   = 1'b0;
                            status    = ST_DONE;
                        end
                    end else begin
                        n_period = r_period + HALF_W'(1);
                    end
                end
            end
            OP_ENDSTOP: begin
                n_running = 1'b0;
                n_drivers = 1'b0;
                n_level   = 1'b0;
                n_period  = '0;
                status    = ST_ENDSTOP;
            end
            default: begin
            end
        endcase

        o_pulse.step_level = n_level;
        o_pulse.drivers_on = n_drivers;
        o_pulse.status     = status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps   <= '0;
            r_toggles <= '0;
            r_period  <= '0;
            r_running <= 1'b0;
            r_level   <= 1'b0;
            r_drivers <= 1'b0;
        end else if (i_accept) begin
            r_steps   <= n_steps;
            r_toggles <= n_toggles;
            r_period  <= n_period;
            r_running <= n_running;
            r_level   <= n_level;
            r_drivers <= n_drivers;
        end
    end

endmodule
